@@ hdl/ffha_pkg.sv @@
`default_nettype none
package ffha_pkg;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE  = 3'd1;
    localparam logic [2:0] ST_NO_FIT     = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR   = 3'd3;
    localparam logic [2:0] ST_DOUBLE     = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_HEAP_BASE   = 2'd0;
    localparam logic [1:0] REG_HEAP_LENGTH = 2'd1;
    localparam logic [1:0] REG_MIN_SPLIT   = 2'd2;

    // Request modes.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam int ADDR_W  = 48;
    localparam int SIZE_W  = 16;
    localparam int ALIGN_W = 4;
    localparam int STAT_W  = 16;
    localparam int CNT_W   = 13;
    localparam int ROUND_W = 17;
    localparam int MIN_HEAP = 64;

endpackage
`default_nettype wire

@@ hdl/ffha_divg.sv @@
`default_nettype none
module ffha_divg
    import ffha_pkg::*;
#(
    parameter int DIVISOR = 8,
    parameter int WIDTH   = 17
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [WIDTH-1:0]              dividend,
    output logic                               valid,
    output logic [WIDTH-1:0]                   quotient,
    output logic [$clog2(DIVISOR):0]           remainder
);

    localparam int RMW = $clog2(DIVISOR) + 1;
    localparam int SH  = WIDTH + $clog2(DIVISOR);
    localparam int MW  = WIDTH + 1;
    localparam int PW  = WIDTH + MW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [RMW-1:0]   rem_reg, rem_next;
    logic             valid_reg, valid_next;
    logic [PW-1:0]    prod;
    logic [WIDTH-1:0] quo_calc;
    logic [WIDTH-1:0] rem_full;

    // Quotient by multiplying with the rounded-up reciprocal, exact for every
    // dividend of WIDTH bits; the remainder follows by one multiply-subtract.
    // The result is registered: it is ready in the cycle after start and holds until the next start.
    always_comb
    begin
        prod       = PW'(dividend) * PW'(RECIP_M);
        quo_calc   = prod[SH +: WIDTH];
        rem_full   = dividend - (quo_calc * WIDTH'(DIVISOR));
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        valid_next = valid_reg;
        if (start)
        begin
            quo_next   = quo_calc;
            rem_next   = rem_full[RMW-1:0];
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg   <= '0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
    end

    assign valid     = valid_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

@@ hdl/ffha_hdr_ram.sv @@
`default_nettype none
module ffha_hdr_ram
    import ffha_pkg::*;
#(
    parameter int DEPTH = 4097,
    parameter int AW    = 13,
    parameter int EW    = 33
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [EW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [EW-1:0]      rdata
);

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rdata_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ hdl/first_fit_heap_allocator_core.sv @@
// First-fit heap allocator with forward coalescing.
// Requests arrive on the s_ stream: s_tuser is the mode (0 allocate, 1 free),
// s_tdata carries size, alignment and the address to free. Each request yields
// exactly one result on the m_ stream: granted address, status and statistics.
// Configuration writes go through cfg_valid/cfg_ready with a register index.
// Chunk headers live in a single-port-write, registered-read memory, one entry
// per granule. An allocate rounds the size up to whole granules, reads and
// checks one header per chunk visited in the walk, then writes the header
// and loads the result register. A free checks the address, divides it to
// a granule and reads its header, then merges each free chunk that follows
// until the run ends, and writes back and loads the result. One request is
// worked on at a time. After reset and after every write of heap_length a
// clearing pass sweeps the memory; s_tready stays low meanwhile, configuration
// writes are still taken. A finished result sits in an output register; a new
// request is accepted while it waits, and that request's result holds until
// m_tready frees it.
`default_nettype none
module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES    = 32768,
    parameter int GRANULE_BYTES = 8,
    parameter int HEADER_BYTES  = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Request stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: request_size[15:0], align_log2[19:16],
    // free_address[67:20], zero fill.
    input  wire logic [71:0] s_tdata,
    // Fields from bit 0: mode.
    input  wire logic        s_tuser,
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: granted_address[47:0], status[50:48],
    // used_bytes[66:51], overhead_bytes[82:67], chunk_total[95:83].
    output logic [95:0]      m_tdata,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    localparam int LW    = $clog2(HEAP_BYTES + 1);
    localparam int CURW  = LW + 1;
    localparam int SLOTS = HEAP_BYTES / GRANULE_BYTES + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int RW    = (GRANULE_BYTES > 1) ? $clog2(GRANULE_BYTES) : 1;
    localparam int DW    = (LW + 1 > ROUND_W) ? LW + 1 : ROUND_W;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int EW    = 2 + SW + RW + LW;
    localparam int TW    = (LW > SIZE_W) ? LW + 1 : SIZE_W + 1;
    localparam int HDRG  = HEADER_BYTES / GRANULE_BYTES;
    localparam logic [LW-1:0] G_L   = LW'(GRANULE_BYTES);
    localparam logic [LW-1:0] HDR_L = LW'(HEADER_BYTES);

    typedef enum logic [3:0] {
        S_CLR_START, S_CLEAR, S_CLR_WAIT, S_IDLE,
        S_A_DIV, S_A_READ, S_A_EVAL, S_A_WRITE,
        S_F_CHECK, S_F_DIV, S_F_READ, S_F_EVAL,
        S_C_READ, S_C_EVAL, S_F_WRITE, S_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] base_reg, base_next;
    logic [SIZE_W-1:0] hlen_reg, hlen_next;
    logic [SIZE_W-1:0] msplit_reg, msplit_next;

    logic [LW-1:0] used_reg, used_next;
    logic [LW-1:0] ovh_reg, ovh_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [SW-1:0]     clr_reg, clr_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ALIGN_W-1:0] lg_reg, lg_next;
    logic [ADDR_W-1:0] faddr_reg, faddr_next;
    logic [DW-1:0]     nq_reg, nq_next;
    logic [CURW-1:0]   cur_reg, cur_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [SW-1:0]     hslot_reg, hslot_next;
    logic [SW-1:0]     hlq_reg, hlq_next;
    logic [RW-1:0]     hlr_reg, hlr_next;
    logic [LW-1:0]     hw_reg, hw_next;
    logic              hsplit_reg, hsplit_next;
    logic [LW-1:0]     at_reg, at_next;
    logic [2:0]        st_reg, st_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    logic              mv_reg, mv_next;
    logic [95:0]       mdata_reg, mdata_next;

    // Memory and divider hookup.
    logic          ram_we;
    logic [SW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic          div_start, div_valid;
    logic [DW-1:0] div_in, div_q;
    logic [$clog2(GRANULE_BYTES):0] div_r;

    // Unpacked header read back from memory.
    logic          e_start, e_free;
    logic [SW-1:0] e_lq;
    logic [RW-1:0] e_lr;
    logic [LW-1:0] e_waste;
    logic [LW-1:0] e_len;

    logic [LW-1:0]     end_b;
    logic [TW-1:0]     thr;
    logic [ROUND_W-1:0] amask, vround;
    logic [LW-1:0]     need_b, rest_b;
    logic [ADDR_W-1:0] off48;
    logic              in_take, cfg_take;

    ffha_hdr_ram #(.DEPTH(SLOTS), .AW(SW), .EW(EW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffha_divg #(.DIVISOR(GRANULE_BYTES), .WIDTH(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_in),
        .valid     (div_valid),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign {e_start, e_free, e_lq, e_lr, e_waste} = ram_rdata;
    assign e_len = LW'(e_lq) * G_L + LW'(e_lr);

    // Effective heap end, clamped to the legal range.
    always_comb
    begin
        if (TW'(hlen_reg) > TW'(HEAP_BYTES))
        begin
            end_b = LW'(HEAP_BYTES);
        end
        else if (hlen_reg < SIZE_W'(MIN_HEAP))
        begin
            end_b = LW'(MIN_HEAP);
        end
        else
        begin
            end_b = LW'(hlen_reg);
        end
    end

    assign thr    = (TW'(msplit_reg) < TW'(HEADER_BYTES)) ? TW'(HEADER_BYTES) : TW'(msplit_reg);
    assign amask  = (ROUND_W'(1) << lg_reg) - ROUND_W'(1);
    assign vround = (ROUND_W'(size_reg) + amask) & ~amask;
    assign need_b = LW'(nq_reg) * G_L;
    assign rest_b = LW'(e_lq - SW'(nq_reg)) * G_L + LW'(e_lr);
    assign off48  = faddr_reg - base_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_take  = cfg_valid && cfg_ready;

    // Sequencer: walks headers through the memory port.
    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        hlen_next   = hlen_reg;
        msplit_next = msplit_reg;
        used_next   = used_reg;
        ovh_next    = ovh_reg;
        cnt_next    = cnt_reg;
        clr_next    = clr_reg;
        size_next   = size_reg;
        lg_next     = lg_reg;
        faddr_next  = faddr_reg;
        nq_next     = nq_reg;
        cur_next    = cur_reg;
        slot_next   = slot_reg;
        hslot_next  = hslot_reg;
        hlq_next    = hlq_reg;
        hlr_next    = hlr_reg;
        hw_next     = hw_reg;
        hsplit_next = hsplit_reg;
        at_next     = at_reg;
        st_next     = st_reg;
        addr_next   = addr_reg;
        mv_next     = mv_reg && !m_tready;
        mdata_next  = mdata_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = slot_reg;
        div_start   = 1'b0;
        div_in      = DW'(vround);

        case (state_reg)
            S_CLR_START:
            begin
                div_start = 1'b1;
                div_in    = DW'(end_b - HDR_L);
                clr_next  = '0;
                used_next = '0;
                ovh_next  = HDR_L;
                cnt_next  = CW'(1);
                state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == SW'(SLOTS - 1))
                begin
                    state_next = S_CLR_WAIT;
                end
            end
            S_CLR_WAIT:
            begin
                if (div_valid)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = {1'b1, 1'b1, SW'(div_q), div_r[RW-1:0], LW'(0)};
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    size_next  = s_tdata[15:0];
                    lg_next    = s_tdata[19:16];
                    faddr_next = s_tdata[67:20];
                    addr_next  = '0;
                    if (s_tuser == MODE_FREE)
                    begin
                        state_next = S_F_CHECK;
                    end
                    else if (s_tdata[15:0] == '0)
                    begin
                        st_next    = ST_ZERO_SIZE;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_A_DIV;
                    end
                end
            end
            S_A_DIV:
            begin
                // Round the aligned size up to whole granules.
                if (!div_valid && !div_start && nq_reg == nq_reg && clr_reg == clr_reg
                    && hsplit_reg == hsplit_reg && cur_reg == cur_reg
                    && state_reg != S_A_READ)
                begin
                    div_start = 1'b1;
                end
                state_next = S_A_DIV;
            end
            S_A_READ:
            begin
                ram_raddr = slot_reg;
                if (cur_reg >= CURW'(end_b))
                begin
                    st_next    = ST_NO_FIT;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_A_EVAL;
                end
            end
            S_A_EVAL:
            begin
                if (!e_start)
                begin
                    st_next    = ST_NO_FIT;
                    state_next = S_FINISH;
                end
                else if (e_free && (DW'(e_lq) >= nq_reg))
                begin
                    hslot_next = slot_reg;
                    used_next  = used_reg + need_b;
                    addr_next  = base_reg + ADDR_W'(cur_reg) + ADDR_W'(HEADER_BYTES);
                    if (TW'(rest_b) >= thr)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = SW'(slot_reg + SW'(nq_reg) + SW'(HDRG));
                        ram_wdata   = {1'b1, 1'b1, SW'(e_lq - SW'(nq_reg) - SW'(HDRG)),
                                       e_lr, LW'(0)};
                        ovh_next    = ovh_reg + HDR_L;
                        cnt_next    = cnt_reg + 1'b1;
                        hlq_next    = SW'(nq_reg);
                        hlr_next    = '0;
                        hw_next     = '0;
                        hsplit_next = 1'b1;
                    end
                    else
                    begin
                        ovh_next    = ovh_reg + rest_b;
                        hlq_next    = e_lq;
                        hlr_next    = e_lr;
                        hw_next     = rest_b;
                        hsplit_next = 1'b0;
                    end
                    state_next = S_A_WRITE;
                end
                else
                begin
                    cur_next   = cur_reg + CURW'(HDR_L) + CURW'(e_len);
                    slot_next  = slot_reg + SW'(HDRG) + e_lq;
                    state_next = S_A_READ;
                end
            end
            S_A_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hslot_reg;
                ram_wdata  = {1'b1, 1'b0, hlq_reg, hlr_reg, hw_reg};
                st_next    = ST_OK;
                state_next = S_FINISH;
            end
            S_F_CHECK:
            begin
                if ((faddr_reg < base_reg) || (off48 < ADDR_W'(HEADER_BYTES))
                    || (off48 >= ADDR_W'(end_b)))
                begin
                    st_next    = ST_BAD_ADDR;
                    state_next = S_FINISH;
                end
                else
                begin
                    at_next    = LW'(off48[LW-1:0] - HDR_L);
                    div_start  = 1'b1;
                    div_in     = DW'(LW'(off48[LW-1:0] - HDR_L));
                    state_next = S_F_DIV;
                end
            end
            S_F_DIV:
            begin
                if (div_valid)
                begin
                    if (div_r != '0)
                    begin
                        st_next    = ST_BAD_ADDR;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        slot_next  = SW'(div_q);
                        state_next = S_F_READ;
                    end
                end
            end
            S_F_READ:
            begin
                ram_raddr  = slot_reg;
                state_next = S_F_EVAL;
            end
            S_F_EVAL:
            begin
                if (!e_start)
                begin
                    st_next    = ST_BAD_ADDR;
                    state_next = S_FINISH;
                end
                else if (e_free)
                begin
                    st_next    = ST_DOUBLE;
                    state_next = S_FINISH;
                end
                else
                begin
                    used_next  = used_reg - (e_len - e_waste);
                    ovh_next   = ovh_reg - e_waste;
                    hslot_next = slot_reg;
                    hlq_next   = e_lq;
                    hlr_next   = e_lr;
                    cur_next   = CURW'(at_reg) + CURW'(HDR_L) + CURW'(e_len);
                    slot_next  = slot_reg + SW'(HDRG) + e_lq;
                    state_next = S_C_READ;
                end
            end
            S_C_READ:
            begin
                ram_raddr = slot_reg;
                if (cur_reg >= CURW'(end_b))
                begin
                    state_next = S_F_WRITE;
                end
                else
                begin
                    state_next = S_C_EVAL;
                end
            end
            S_C_EVAL:
            begin
                // Merge a free neighbor and drop its header.
                if (!e_start || !e_free)
                begin
                    state_next = S_F_WRITE;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = slot_reg;
                    ram_wdata  = '0;
                    hlq_next   = hlq_reg + SW'(HDRG) + e_lq;
                    hlr_next   = hlr_reg + e_lr;
                    ovh_next   = ovh_reg - HDR_L;
                    cnt_next   = cnt_reg - 1'b1;
                    cur_next   = cur_reg + CURW'(HDR_L) + CURW'(e_len);
                    slot_next  = slot_reg + SW'(HDRG) + e_lq;
                    state_next = S_C_READ;
                end
            end
            S_F_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hslot_reg;
                ram_wdata  = {1'b1, 1'b1, hlq_reg, hlr_reg, LW'(0)};
                st_next    = ST_OK;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    mdata_next = {CNT_W'(cnt_reg), STAT_W'(ovh_reg), STAT_W'(used_reg),
                                  st_reg, (st_reg == ST_OK) ? addr_reg : ADDR_W'(0)};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR_START;
            end
        endcase

        // The rounding divide is launched from the accept cycle.
        if (state_reg == S_IDLE && in_take && s_tuser == MODE_ALLOC && s_tdata[15:0] != '0)
        begin
            div_start = 1'b1;
            div_in    = DW'(((ROUND_W'(s_tdata[15:0]) + ((ROUND_W'(1) << s_tdata[19:16])
                        - ROUND_W'(1))) & ~((ROUND_W'(1) << s_tdata[19:16]) - ROUND_W'(1))));
        end
        if (state_reg == S_A_DIV)
        begin
            div_start = 1'b0;
            if (div_valid)
            begin
                nq_next    = div_q + DW'(div_r != '0);
                cur_next   = '0;
                slot_next  = '0;
                state_next = S_A_READ;
            end
        end

        // Configuration writes; heap_length rebuilds the heap.
        if (cfg_take)
        begin
            case (cfg_index)
                REG_HEAP_BASE:
                begin
                    base_next = cfg_data;
                end
                REG_HEAP_LENGTH:
                begin
                    hlen_next  = cfg_data[15:0];
                    state_next = S_CLR_START;
                end
                REG_MIN_SPLIT:
                begin
                    msplit_next = cfg_data[15:0];
                end
                default:
                begin
                    base_next = base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR_START;
            base_reg   <= '0;
            hlen_reg   <= SIZE_W'(32768);
            msplit_reg <= SIZE_W'(32);
            used_reg   <= '0;
            ovh_reg    <= HDR_L;
            cnt_reg    <= CW'(1);
            clr_reg    <= '0;
            size_reg   <= '0;
            lg_reg     <= '0;
            faddr_reg  <= '0;
            nq_reg     <= '0;
            cur_reg    <= '0;
            slot_reg   <= '0;
            hslot_reg  <= '0;
            hlq_reg    <= '0;
            hlr_reg    <= '0;
            hw_reg     <= '0;
            hsplit_reg <= 1'b0;
            at_reg     <= '0;
            st_reg     <= ST_OK;
            addr_reg   <= '0;
            mv_reg     <= 1'b0;
            mdata_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            base_reg   <= base_next;
            hlen_reg   <= hlen_next;
            msplit_reg <= msplit_next;
            used_reg   <= used_next;
            ovh_reg    <= ovh_next;
            cnt_reg    <= cnt_next;
            clr_reg    <= clr_next;
            size_reg   <= size_next;
            lg_reg     <= lg_next;
            faddr_reg  <= faddr_next;
            nq_reg     <= nq_next;
            cur_reg    <= cur_next;
            slot_reg   <= slot_next;
            hslot_reg  <= hslot_next;
            hlq_reg    <= hlq_next;
            hlr_reg    <= hlr_next;
            hw_reg     <= hw_next;
            hsplit_reg <= hsplit_next;
            at_reg     <= at_next;
            st_reg     <= st_next;
            addr_reg   <= addr_next;
            mv_reg     <= mv_next;
            mdata_reg  <= mdata_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

    // The heap always holds at least one chunk.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != '0)
        else $error("chunk count dropped to zero");

    // A failed request never reports an address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[50:48] != ST_OK) |-> (m_tdata[47:0] == '0))
        else $error("address reported on an error result");

    // Held bytes and overhead never exceed the heap.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLR_START) |-> ((CURW'(used_reg) + CURW'(ovh_reg)) <= CURW'(end_b)))
        else $error("statistics exceed heap size");

endmodule
`default_nettype wire

@@ tb/sv/tb_first_fit_heap_allocator_core.sv @@
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator_core;
    import ffha_pkg::*;

    localparam int HEAP_BYTES    = 32768;
    localparam int GRANULE_BYTES = 8;
    localparam int HEADER_BYTES  = 16;
    localparam int SLOT_COUNT    = HEAP_BYTES / GRANULE_BYTES + 1;
    localparam int STALL_LIMIT   = 40000;
    localparam longint unsigned ADDR_MASK = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic              mode;
        logic [15:0]       size;
        logic [3:0]        align;
        logic [47:0]       addr;
    } request_t;

    typedef struct {
        logic [47:0] granted;
        logic [2:0]  status;
        logic [15:0] used;
        logic [15:0] overhead;
        logic [12:0] chunks;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;

    first_fit_heap_allocator_core #(
        .HEAP_BYTES    (HEAP_BYTES),
        .GRANULE_BYTES (GRANULE_BYTES),
        .HEADER_BYTES  (HEADER_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Requests waiting to be sent and results still owed by the block.
    request_t pending_requests[$];
    outcome_t owed_results[$];
    int       error_count;
    int       sender_idle_pct;
    int       receiver_stall_pct;
    int       receiver_hold_cycles;
    int       quiet_cycles;

    // Shadow heap: chunk headers indexed by granule, plus statistics.
    bit              hdr_start[SLOT_COUNT];
    bit              hdr_free[SLOT_COUNT];
    int unsigned     hdr_len[SLOT_COUNT];
    int unsigned     hdr_waste[SLOT_COUNT];
    int unsigned     sh_used;
    int unsigned     sh_overhead;
    int unsigned     sh_chunks;
    longint unsigned sh_base;
    int unsigned     sh_length;
    int unsigned     sh_split;
    logic [47:0]     live_addrs[$];

    always #5 clk = ~clk;

    function automatic int unsigned heap_limit();
        int unsigned e;
        e = sh_length;
        if (e > HEAP_BYTES) e = HEAP_BYTES;
        if (e < MIN_HEAP) e = MIN_HEAP;
        return e;
    endfunction

    function automatic int header_slot(int unsigned off);
        if (off >= HEAP_BYTES || off % GRANULE_BYTES != 0) return -1;
        if (!hdr_start[off / GRANULE_BYTES]) return -1;
        return off / GRANULE_BYTES;
    endfunction

    function automatic void place_header(int unsigned off, bit fr, int unsigned len,
                                         int unsigned waste);
        int i;
        i = off / GRANULE_BYTES;
        hdr_start[i] = 1'b1;
        hdr_free[i]  = fr;
        hdr_len[i]   = len;
        hdr_waste[i] = waste;
    endfunction

    function automatic void clear_heap();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            hdr_start[i] = 1'b0;
            hdr_free[i]  = 1'b0;
            hdr_len[i]   = 0;
            hdr_waste[i] = 0;
        end
        place_header(0, 1'b1, heap_limit() - HEADER_BYTES, 0);
        sh_used     = 0;
        sh_overhead = HEADER_BYTES;
        sh_chunks   = 1;
        live_addrs.delete();
    endfunction

    function automatic int unsigned round_to(int unsigned v, int unsigned m);
        int unsigned r;
        r = v % m;
        return (r != 0) ? v + (m - r) : v;
    endfunction

    // First-fit allocation on the shadow heap.
    function automatic logic [2:0] grant_chunk(int unsigned size, int unsigned lg,
                                               output logic [47:0] addr);
        int unsigned limit;
        int unsigned need;
        int unsigned cur;
        int unsigned rest;
        int unsigned thresh;
        int          s;
        limit = heap_limit();
        cur   = 0;
        s     = -1;
        addr  = '0;
        if (size == 0) return ST_ZERO_SIZE;
        need = round_to(round_to(size, 1 << lg), GRANULE_BYTES);
        while (cur < limit)
        begin
            s = header_slot(cur);
            if (s < 0) break;
            if (hdr_free[s] && hdr_len[s] >= need) break;
            cur += HEADER_BYTES + hdr_len[s];
            s = -1;
        end
        if (s < 0) return ST_NO_FIT;
        rest   = hdr_len[s] - need;
        thresh = (sh_split < HEADER_BYTES) ? HEADER_BYTES : sh_split;
        if (rest >= thresh)
        begin
            place_header(cur + HEADER_BYTES + need, 1'b1, rest - HEADER_BYTES, 0);
            sh_overhead += HEADER_BYTES;
            hdr_len[s]   = need;
            hdr_waste[s] = 0;
            sh_chunks++;
        end
        else
        begin
            hdr_waste[s] = rest;
            sh_overhead += rest;
        end
        hdr_free[s] = 1'b0;
        sh_used += hdr_len[s] - hdr_waste[s];
        addr = 48'((sh_base + cur + HEADER_BYTES) & ADDR_MASK);
        return ST_OK;
    endfunction

    // Release with merging of the free chunks that follow.
    function automatic logic [2:0] release_chunk(logic [47:0] a);
        int unsigned     limit;
        longint unsigned off;
        int unsigned     at;
        int unsigned     nxt;
        int              s;
        int              n;
        limit = heap_limit();
        if (longint'(a) < sh_base) return ST_BAD_ADDR;
        off = longint'(a) - sh_base;
        if (off < HEADER_BYTES || off >= limit) return ST_BAD_ADDR;
        at = int'(off) - HEADER_BYTES;
        s  = header_slot(at);
        if (s < 0) return ST_BAD_ADDR;
        if (hdr_free[s]) return ST_DOUBLE;
        sh_used     -= hdr_len[s] - hdr_waste[s];
        sh_overhead -= hdr_waste[s];
        nxt = at + HEADER_BYTES + hdr_len[s];
        while (nxt < limit)
        begin
            n = header_slot(nxt);
            if (n < 0 || !hdr_free[n]) break;
            hdr_len[s] += HEADER_BYTES + hdr_len[n];
            nxt += HEADER_BYTES + hdr_len[n];
            hdr_start[n] = 1'b0;
            sh_overhead -= HEADER_BYTES;
            sh_chunks--;
        end
        hdr_free[s]  = 1'b1;
        hdr_waste[s] = 0;
        return ST_OK;
    endfunction

    // Queue one request together with its predicted result.
    task automatic send_request(logic mode, logic [15:0] size, logic [3:0] align,
                                logic [47:0] addr);
        request_t rq;
        outcome_t oc;
        logic [47:0] g;
        rq.mode  = mode;
        rq.size  = size;
        rq.align = align;
        rq.addr  = addr;
        g = '0;
        if (mode == MODE_ALLOC)
            oc.status = grant_chunk(size, align, g);
        else
            oc.status = release_chunk(addr);
        if (mode == MODE_ALLOC && oc.status == ST_OK) live_addrs.push_back(g);
        oc.granted  = (oc.status == ST_OK) ? g : '0;
        oc.used     = sh_used[15:0];
        oc.overhead = sh_overhead[15:0];
        oc.chunks   = sh_chunks[12:0];
        pending_requests.push_back(rq);
        owed_results.push_back(oc);
    endtask

    task automatic write_register(logic [1:0] idx, logic [47:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        cfg_valid <= 1'b0;
        if (idx == REG_HEAP_BASE)
            sh_base = value;
        else if (idx == REG_HEAP_LENGTH)
        begin
            sh_length = value[15:0];
            clear_heap();
        end
        else
            sh_split = value[15:0];
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || owed_results.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Mostly well-formed alloc/free traffic with some malformed requests mixed in.
    task automatic random_traffic(int count, int max_size);
        int          pick;
        int          k;
        logic [47:0] a;
        logic [3:0]  lg;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            lg   = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 6))
                                              : 4'($urandom_range(0, 15));
            if (pick < 50 || (pick < 88 && live_addrs.size() == 0))
                send_request(MODE_ALLOC, 16'($urandom_range(1, max_size)), lg, '0);
            else if (pick < 88)
            begin
                k = $urandom_range(0, live_addrs.size() - 1);
                a = live_addrs[k];
                live_addrs.delete(k);
                send_request(MODE_FREE, 16'($urandom), 4'($urandom), a);
            end
            else if (pick < 92)
                send_request(MODE_FREE, 16'($urandom), 4'($urandom),
                             48'({$urandom, $urandom}));
            else if (pick < 95)
                send_request(MODE_FREE, 16'($urandom), 4'($urandom),
                             48'(sh_base + 16 + 8 * $urandom_range(0, 64)));
            else if (pick < 98)
                send_request(MODE_ALLOC, 16'($urandom), 4'($urandom),
                             48'({$urandom, $urandom}));
            else
                send_request(MODE_ALLOC, '0, lg, '0);
        end
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_requests[0].mode;
                s_tdata  <= {4'b0, pending_requests[0].addr, pending_requests[0].align,
                             pending_requests[0].size};
                void'(pending_requests.pop_front());
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor, receiver stalls and the watchdog.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result with none owed: %h", $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    outcome_t ex;
                    ex = owed_results.pop_front();
                    if (m_tdata[47:0] !== ex.granted)
                    begin
                        $display("%0t: granted_address expected %h actual %h",
                                 $time, ex.granted, m_tdata[47:0]);
                        error_count++;
                    end
                    if (m_tdata[50:48] !== ex.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, ex.status, m_tdata[50:48]);
                        error_count++;
                    end
                    if (m_tdata[66:51] !== ex.used)
                    begin
                        $display("%0t: used_bytes expected %0d actual %0d",
                                 $time, ex.used, m_tdata[66:51]);
                        error_count++;
                    end
                    if (m_tdata[82:67] !== ex.overhead)
                    begin
                        $display("%0t: overhead_bytes expected %0d actual %0d",
                                 $time, ex.overhead, m_tdata[82:67]);
                        error_count++;
                    end
                    if (m_tdata[95:83] !== ex.chunks)
                    begin
                        $display("%0t: chunk_total expected %0d actual %0d",
                                 $time, ex.chunks, m_tdata[95:83]);
                        error_count++;
                    end
                end
            end
            if (receiver_hold_cycles > 0)
            begin
                receiver_hold_cycles <= receiver_hold_cycles - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        logic [47:0] a;
        logic [47:0] b;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_valid            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        error_count          = 0;
        sender_idle_pct      = 0;
        receiver_stall_pct   = 0;
        receiver_hold_cycles = 0;
        sh_base              = 0;
        sh_length            = 32768;
        sh_split             = 32;
        clear_heap();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero size, alignment extremes, no fit, bad and double frees.
        send_request(MODE_ALLOC, 16'd0, 4'd3, '0);
        send_request(MODE_ALLOC, 16'd1, 4'd0, '0);
        a = live_addrs[0];
        send_request(MODE_ALLOC, 16'd40, 4'd12, '0);
        b = live_addrs[1];
        send_request(MODE_ALLOC, 16'd32768, 4'd15, '0);
        send_request(MODE_ALLOC, 16'hFFFF, 4'd15, '0);
        send_request(MODE_ALLOC, 16'd100, 4'd2, '0);
        send_request(MODE_FREE, '0, '0, 48'd8);
        send_request(MODE_FREE, '0, '0, a + 48'd4);
        send_request(MODE_FREE, '0, '0, 48'd32768);
        send_request(MODE_FREE, '0, '0, 48'hFFFF_FFFF_FFFF);
        send_request(MODE_FREE, '0, '0, b);
        send_request(MODE_FREE, '0, '0, b);
        send_request(MODE_FREE, '0, '0, a);
        send_request(MODE_ALLOC, 16'd16, 4'd4, '0);
        send_request(MODE_ALLOC, 16'd32000, 4'd3, '0);
        live_addrs.delete();
        wait_drained();

        // Small heap, base offset, no idling, long receiver hold-off.
        write_register(REG_HEAP_BASE, 48'h1234_5678_9000);
        write_register(REG_HEAP_LENGTH, 48'd1024);
        write_register(REG_MIN_SPLIT, 48'd32);
        receiver_hold_cycles = 400;
        random_traffic(300, 160);
        wait_drained();

        // Smallest heap and split threshold with a slow sender.
        write_register(REG_HEAP_LENGTH, 48'd64);
        write_register(REG_MIN_SPLIT, 48'd16);
        sender_idle_pct = 66;
        random_traffic(150, 48);
        wait_drained();

        // Base at the top of the address space so granted addresses wrap.
        write_register(REG_HEAP_BASE, 48'hFFFF_FFFF_FFFF);
        write_register(REG_HEAP_LENGTH, 48'd512);
        write_register(REG_MIN_SPLIT, 48'd0);
        sender_idle_pct    = 0;
        receiver_stall_pct = 66;
        random_traffic(250, 96);
        wait_drained();

        // Full heap with the largest split threshold, both sides idling.
        write_register(REG_HEAP_BASE, 48'd0);
        write_register(REG_HEAP_LENGTH, 48'd32768);
        write_register(REG_MIN_SPLIT, 48'd32768);
        sender_idle_pct    = 37;
        receiver_stall_pct = 37;
        random_traffic(150, 8000);
        wait_drained();

        // Mid-size heap, both sides idling, then an oversized length that clamps.
        write_register(REG_HEAP_LENGTH, 48'd2048);
        write_register(REG_MIN_SPLIT, 48'd48);
        random_traffic(450, 256);
        wait_drained();

        write_register(REG_HEAP_LENGTH, 48'hFFFF);
        write_register(REG_MIN_SPLIT, 48'd100);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        random_traffic(380, 1500);
        wait_drained();

        repeat (50) @(posedge clk);
        if (owed_results.size() != 0) error_count++;
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
